// ----- hdl/ftsl_pkg.sv -----
`default_nettype none

package ftsl_pkg;

  localparam int MAX_WIDTH_DEFAULT  = 64;
  localparam int MAX_HEIGHT_DEFAULT = 64;

  localparam logic [1:0] MODE_HORIZONTAL = 2'd0;
  localparam logic [1:0] MODE_VERTICAL   = 2'd1;
  localparam logic [1:0] MODE_TWO_D      = 2'd2;

  localparam logic [1:0] PHASE_QUARTER       = 2'd1;
  localparam logic [1:0] PHASE_HALF          = 2'd2;
  localparam logic [1:0] PHASE_THREE_QUARTER = 2'd3;

  localparam logic [1:0] REG_FILTER_MODE  = 2'd0;
  localparam logic [1:0] REG_PHASE        = 2'd1;
  localparam logic [1:0] REG_BLOCK_WIDTH  = 2'd2;
  localparam logic [1:0] REG_BLOCK_HEIGHT = 2'd3;

  localparam logic [1:0] FILTER_MODE_RESET  = MODE_HORIZONTAL;
  localparam logic [1:0] PHASE_RESET        = PHASE_HALF;
  localparam logic [6:0] BLOCK_WIDTH_RESET  = 7'd8;
  localparam logic [6:0] BLOCK_HEIGHT_RESET = 7'd8;

  localparam logic [15:0] ROUND = 16'h0010;
  localparam int          SHIFT = 5;

  typedef struct packed {
    logic       emit;
    logic       last;
    logic       fwr;
    logic [1:0] slot;
  } ctl_t;

  function automatic logic [1:0] slot_inc(input logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic logic [7:0] four_tap(input logic [1:0] ph, input logic [7:0] a,
                                          input logic [7:0] b, input logic [7:0] c,
                                          input logic [7:0] d);
    logic        [15:0] ua;
    logic        [15:0] ub;
    logic        [15:0] uc;
    logic        [15:0] ud;
    logic        [15:0] sum;
    logic signed [15:0] v;
    ua = {8'd0, a};
    ub = {8'd0, b};
    uc = {8'd0, c};
    ud = {8'd0, d};
    case (ph)
      PHASE_QUARTER:       sum = ub * 16'd25 + uc * 16'd9 - ua - ud;
      PHASE_THREE_QUARTER: sum = ub * 16'd9 + uc * 16'd25 - ua - ud;
      default:             sum = (ub + uc) * 16'd18 - ((ua + ud) << 1);
    endcase
    v = $signed(sum + ROUND) >>> SHIFT;
    if (v < 16'sd0) begin
      return 8'd0;
    end else if (v > 16'sd255) begin
      return 8'hFF;
    end
    return v[7:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/ftsl_line_ram.sv -----
`default_nettype none

module ftsl_line_ram #(
  parameter int DEPTH = 67,
  parameter int AW    = 7
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/ftsl_window_ctrl.sv -----
`default_nettype none

module ftsl_window_ctrl #(
  parameter  int MAX_WIDTH  = ftsl_pkg::MAX_WIDTH_DEFAULT,
  parameter  int MAX_HEIGHT = ftsl_pkg::MAX_HEIGHT_DEFAULT,
  localparam int CW         = $clog2(MAX_WIDTH + 3),
  localparam int RW         = $clog2(MAX_HEIGHT + 3),
  localparam int FAW        = $clog2(MAX_WIDTH)
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire logic           clear,
  input  wire logic [1:0]     filter_mode,
  input  wire logic [6:0]     block_width,
  input  wire logic [6:0]     block_height,
  output ftsl_pkg::ctl_t      ctl,
  output logic      [CW-1:0]  col,
  output logic      [CW-1:0]  rd_col,
  output logic      [FAW-1:0] rd_x,
  output logic      [FAW-1:0] xaddr
);

  logic [CW-1:0] col_next;
  logic [RW-1:0] row;
  logic [RW-1:0] row_next;
  logic [1:0]    slot;
  logic [1:0]    slot_next;
  logic [7:0]    bw8;
  logic [7:0]    bh8;
  logic [7:0]    w8;
  logic [7:0]    h8;
  logic [CW-1:0] w;
  logic [CW-1:0] last_col;
  logic [RW-1:0] h;
  logic [RW-1:0] last_row;
  logic          is_h;
  logic          is_v;
  logic          col_ge3;
  logic          row_ge3;

  assign bw8 = {1'b0, block_width};
  assign bh8 = {1'b0, block_height};
  assign w8  = (bw8 == 8'd0) ? 8'd1 : ((bw8 > 8'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : bw8);
  assign h8  = (bh8 == 8'd0) ? 8'd1 : ((bh8 > 8'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : bh8);
  assign w        = CW'(w8);
  assign h        = RW'(h8);
  assign last_col = w + CW'(2);
  assign last_row = h + RW'(2);

  assign is_h    = (filter_mode == ftsl_pkg::MODE_HORIZONTAL);
  assign is_v    = (filter_mode == ftsl_pkg::MODE_VERTICAL);
  assign col_ge3 = (col >= CW'(3));
  assign row_ge3 = (row >= RW'(3));

  always_comb begin
    ctl.slot = slot;
    ctl.fwr  = !is_h && !is_v && col_ge3;
    if (is_h) begin
      ctl.emit = col_ge3 && (row != '0) && (row <= h);
      ctl.last = (row == h) && (col == last_col);
    end else if (is_v) begin
      ctl.emit = (col != '0) && (col <= w) && row_ge3;
      ctl.last = (row == last_row) && (col == w);
    end else begin
      ctl.emit = col_ge3 && row_ge3;
      ctl.last = (row == last_row) && (col == last_col);
    end
  end

  always_comb begin
    if (col == last_col) begin
      col_next = '0;
      if (row == last_row) begin
        row_next  = '0;
        slot_next = 2'd0;
      end else begin
        row_next  = row + RW'(1);
        slot_next = ftsl_pkg::slot_inc(slot);
      end
    end else begin
      col_next  = col + CW'(1);
      row_next  = row;
      slot_next = slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      col  <= '0;
      row  <= '0;
      slot <= 2'd0;
    end else if (accept) begin
      col  <= col_next;
      row  <= row_next;
      slot <= slot_next;
    end
  end

  assign rd_col = clear ? '0 : (accept ? col_next : col);
  assign rd_x   = (rd_col >= CW'(3)) ? FAW'(rd_col - CW'(3)) : '0;
  assign xaddr  = FAW'(col - CW'(3));

  a_slot_range: assert property (@(posedge clk) disable iff (rst) slot != 2'd3)
    else $error("row slot out of range");

  a_col_bound: assert property (@(posedge clk) disable iff (rst) col <= last_col)
    else $error("column count beyond window");

  a_row_bound: assert property (@(posedge clk) disable iff (rst) row <= last_row)
    else $error("row count beyond window");

  a_two_d_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && ctl.emit && ctl.last && !is_h && !is_v |=> (col == '0) && (row == '0))
    else $error("window did not restart after last two-dimensional pixel");

endmodule

`default_nettype wire

// ----- hdl/ftsl_filter_pipe.sv -----
`default_nettype none

module ftsl_filter_pipe #(
  parameter int FAW = 6
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [1:0]     filter_mode,
  input  wire logic [1:0]     phase,
  input  wire logic           pixel_valid,
  output logic                pixel_ready,
  input  wire logic [7:0]     ref_pixel,
  input  wire logic [7:0]     sh0,
  input  wire logic [7:0]     sh1,
  input  wire logic [7:0]     sh2,
  input  wire logic [7:0]     ra,
  input  wire logic [7:0]     rb,
  input  wire logic [7:0]     rc,
  input  wire logic [7:0]     fa,
  input  wire logic [7:0]     fb,
  input  wire logic [7:0]     fc,
  input  wire ftsl_pkg::ctl_t ctl,
  input  wire logic [FAW-1:0] xaddr,
  output logic                fwr_en,
  output logic      [1:0]     fwr_slot,
  output logic      [FAW-1:0] fwr_addr,
  output logic      [7:0]     fwr_data,
  output logic                result_valid,
  input  wire logic           result_ready,
  output logic      [7:0]     out_pixel,
  output logic                block_end
);

  logic           accept;
  logic           v1;
  logic           v2;
  logic           adv1;
  logic           adv2;
  logic           ready2;
  logic [7:0]     s1_pix;
  logic [7:0]     s1_sh0;
  logic [7:0]     s1_sh1;
  logic [7:0]     s1_sh2;
  logic [7:0]     s1_ra;
  logic [7:0]     s1_rb;
  logic [7:0]     s1_rc;
  logic [7:0]     s1_fa;
  logic [7:0]     s1_fb;
  logic [7:0]     s1_fc;
  ftsl_pkg::ctl_t s1_ctl;
  logic [FAW-1:0] s1_x;
  logic [7:0]     h1;
  logic [7:0]     vr1;
  logic [7:0]     s2_h;
  logic [7:0]     s2_v;
  logic [7:0]     s2_fa;
  logic [7:0]     s2_fb;
  logic [7:0]     s2_fc;
  logic           s2_emit;
  logic           s2_last;
  logic [7:0]     d2;
  logic [7:0]     res2;

  assign adv2        = v2 && (!s2_emit || !result_valid || result_ready);
  assign ready2      = !v2 || adv2;
  assign adv1        = v1 && ready2;
  assign pixel_ready = !v1 || adv1;
  assign accept      = pixel_valid && pixel_ready;

  assign h1  = ftsl_pkg::four_tap(phase, s1_sh0, s1_sh1, s1_sh2, s1_pix);
  assign vr1 = ftsl_pkg::four_tap(phase, s1_ra, s1_rb, s1_rc, s1_pix);

  assign fwr_en   = adv1 && s1_ctl.fwr;
  assign fwr_slot = s1_ctl.slot;
  assign fwr_addr = s1_x;
  assign fwr_data = h1;

  assign d2 = ftsl_pkg::four_tap(phase, s2_fa, s2_fb, s2_fc, s2_h);

  always_comb begin
    if (filter_mode == ftsl_pkg::MODE_HORIZONTAL) begin
      res2 = s2_h;
    end else if (filter_mode == ftsl_pkg::MODE_VERTICAL) begin
      res2 = s2_v;
    end else begin
      res2 = d2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (pixel_ready) begin
      v1 <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix <= ref_pixel;
      s1_sh0 <= sh0;
      s1_sh1 <= sh1;
      s1_sh2 <= sh2;
      s1_ra  <= ra;
      s1_rb  <= rb;
      s1_rc  <= rc;
      s1_fa  <= fa;
      s1_fb  <= fb;
      s1_fc  <= fc;
      s1_ctl <= ctl;
      s1_x   <= xaddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s2_h    <= h1;
      s2_v    <= vr1;
      s2_fa   <= s1_fa;
      s2_fb   <= s1_fb;
      s2_fc   <= s1_fc;
      s2_emit <= s1_ctl.emit;
      s2_last <= s1_ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv2 && s2_emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s2_emit) begin
      out_pixel <= res2;
      block_end <= s2_last;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/four_tap_subpel_luma_filter.sv -----
// Four-tap sub-pixel luma interpolation filter.
// Input: one reference pixel per transfer on pixel_valid/pixel_ready, the padded
// (width+3) x (height+3) window in raster order, origin at block position (-1,-1).
// Output: one interpolated pixel per block position on result_valid/result_ready,
// in raster order of the block; block_end marks the last pixel of the block.
// Border pixels of the window give no result.
// Configuration over the APB port: filter_mode at 0x0, phase at 0x4,
// block_width at 0x8, block_height at 0xC. Any write restarts the window count.
// Throughput: one pixel per cycle unless a stalled receiver holds the output. The pixel
// that completes a result's support passes the input register (loaded at its transfer),
// the horizontal/vertical filter stage and the second filter stage into the output
// register, which raises result_valid.
// Line stores are three row memories each of raw and filtered pixels; their
// registered read port is addressed one pixel ahead.
// Reset returns the registers to mode 0, phase 2, 8 x 8 and starts a new window;
// store contents need no clearing.
// When the receiver stalls, the output register and two internal stages hold;
// pixel_ready falls only once all three are full.
`default_nettype none

module four_tap_subpel_luma_filter #(
  parameter int MAX_WIDTH  = ftsl_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = ftsl_pkg::MAX_HEIGHT_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        pixel_valid,
  output logic             pixel_ready,
  input  wire logic [7:0]  ref_pixel,
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic      [7:0]  out_pixel,
  output logic             block_end
);

  localparam int CW  = $clog2(MAX_WIDTH + 3);
  localparam int FAW = $clog2(MAX_WIDTH);

  logic [1:0]     filter_mode;
  logic [1:0]     phase;
  logic [6:0]     block_width;
  logic [6:0]     block_height;
  logic           cfg_wr;
  logic           accept;
  logic [7:0]     sh0;
  logic [7:0]     sh1;
  logic [7:0]     sh2;
  ftsl_pkg::ctl_t ctl;
  logic [CW-1:0]  col;
  logic [CW-1:0]  rd_col;
  logic [FAW-1:0] rd_x;
  logic [FAW-1:0] xaddr;
  logic [1:0]     slot1;
  logic [1:0]     slot2;
  logic [7:0]     raw_rd  [3];
  logic [7:0]     filt_rd [3];
  logic           fwr_en;
  logic [1:0]     fwr_slot;
  logic [FAW-1:0] fwr_addr;
  logic [7:0]     fwr_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign accept = pixel_valid && pixel_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= ftsl_pkg::FILTER_MODE_RESET;
      phase        <= ftsl_pkg::PHASE_RESET;
      block_width  <= ftsl_pkg::BLOCK_WIDTH_RESET;
      block_height <= ftsl_pkg::BLOCK_HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        ftsl_pkg::REG_FILTER_MODE:  filter_mode  <= pwdata[1:0];
        ftsl_pkg::REG_PHASE:        phase        <= pwdata[1:0];
        ftsl_pkg::REG_BLOCK_WIDTH:  block_width  <= pwdata[6:0];
        ftsl_pkg::REG_BLOCK_HEIGHT: block_height <= pwdata[6:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      ftsl_pkg::REG_FILTER_MODE:  prdata = {30'd0, filter_mode};
      ftsl_pkg::REG_PHASE:        prdata = {30'd0, phase};
      ftsl_pkg::REG_BLOCK_WIDTH:  prdata = {25'd0, block_width};
      ftsl_pkg::REG_BLOCK_HEIGHT: prdata = {25'd0, block_height};
    endcase
  end

  // Last three pixels of the stream
  always_ff @(posedge clk) begin
    if (rst) begin
      sh0 <= 8'd0;
      sh1 <= 8'd0;
      sh2 <= 8'd0;
    end else if (accept) begin
      sh0 <= sh1;
      sh1 <= sh2;
      sh2 <= ref_pixel;
    end
  end

  ftsl_window_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .clear        (cfg_wr),
    .filter_mode  (filter_mode),
    .block_width  (block_width),
    .block_height (block_height),
    .ctl          (ctl),
    .col          (col),
    .rd_col       (rd_col),
    .rd_x         (rd_x),
    .xaddr        (xaddr)
  );

  for (genvar k = 0; k < 3; k++) begin : g_rows
    ftsl_line_ram #(
      .DEPTH (MAX_WIDTH + 3),
      .AW    (CW)
    ) u_raw (
      .clk   (clk),
      .we    (accept && (ctl.slot == 2'(k))),
      .waddr (col),
      .wdata (ref_pixel),
      .raddr (rd_col),
      .rdata (raw_rd[k])
    );

    ftsl_line_ram #(
      .DEPTH (MAX_WIDTH),
      .AW    (FAW)
    ) u_filt (
      .clk   (clk),
      .we    (fwr_en && (fwr_slot == 2'(k))),
      .waddr (fwr_addr),
      .wdata (fwr_data),
      .raddr (rd_x),
      .rdata (filt_rd[k])
    );
  end

  assign slot1 = ftsl_pkg::slot_inc(ctl.slot);
  assign slot2 = ftsl_pkg::slot_inc(slot1);

  ftsl_filter_pipe #(
    .FAW (FAW)
  ) u_pipe (
    .clk          (clk),
    .rst          (rst),
    .filter_mode  (filter_mode),
    .phase        (phase),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .ref_pixel    (ref_pixel),
    .sh0          (sh0),
    .sh1          (sh1),
    .sh2          (sh2),
    .ra           (raw_rd[ctl.slot]),
    .rb           (raw_rd[slot1]),
    .rc           (raw_rd[slot2]),
    .fa           (filt_rd[ctl.slot]),
    .fb           (filt_rd[slot1]),
    .fc           (filt_rd[slot2]),
    .ctl          (ctl),
    .xaddr        (xaddr),
    .fwr_en       (fwr_en),
    .fwr_slot     (fwr_slot),
    .fwr_addr     (fwr_addr),
    .fwr_data     (fwr_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_pixel    (out_pixel),
    .block_end    (block_end)
  );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
module tb;

  localparam int MAX_W = ftsl_pkg::MAX_WIDTH_DEFAULT;
  localparam int MAX_H = ftsl_pkg::MAX_HEIGHT_DEFAULT;
  localparam int LINE  = MAX_W + 3;
  localparam int STALL_CYCLES = 80;

  localparam logic [1:0] MODE_TWO_D_ALIAS = 2'd3;
  localparam logic [1:0] PHASE_HALF_ALIAS = 2'd0;

  typedef struct packed {
    logic [7:0] pix;
    logic       last;
  } subpel_result_t;

  class subpel_checker;
    logic [1:0] mode_reg;
    logic [1:0] phase_reg;
    logic [6:0] width_reg;
    logic [6:0] height_reg;
    logic [7:0] raw_rows [3][LINE];
    logic [7:0] filt_rows [3][MAX_W];
    logic [7:0] tail [3];
    int col;
    int row;
    int errors;
    subpel_result_t pending_pixels [$];

    function new();
      mode_reg   = ftsl_pkg::FILTER_MODE_RESET;
      phase_reg  = ftsl_pkg::PHASE_RESET;
      width_reg  = ftsl_pkg::BLOCK_WIDTH_RESET;
      height_reg = ftsl_pkg::BLOCK_HEIGHT_RESET;
      foreach (raw_rows[i, j]) raw_rows[i][j] = 8'd0;
      foreach (filt_rows[i, j]) filt_rows[i][j] = 8'd0;
      foreach (tail[i]) tail[i] = 8'd0;
      col = 0;
      row = 0;
      errors = 0;
    endfunction

    function int eff_size(input logic [6:0] v, input int maxv);
      if (v == 7'd0) return 1;
      return (int'(v) > maxv) ? maxv : int'(v);
    endfunction

    function int window_len();
      return (eff_size(width_reg, MAX_W) + 3) * (eff_size(height_reg, MAX_H) + 3);
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [31:0] value);
      case (idx)
        ftsl_pkg::REG_FILTER_MODE:  mode_reg = value[1:0];
        ftsl_pkg::REG_PHASE:        phase_reg = value[1:0];
        ftsl_pkg::REG_BLOCK_WIDTH:  width_reg = value[6:0];
        ftsl_pkg::REG_BLOCK_HEIGHT: height_reg = value[6:0];
        default: ;
      endcase
      col = 0;
      row = 0;
    endfunction

    function logic [31:0] reg_value(input logic [1:0] idx);
      case (idx)
        ftsl_pkg::REG_FILTER_MODE:  return {30'd0, mode_reg};
        ftsl_pkg::REG_PHASE:        return {30'd0, phase_reg};
        ftsl_pkg::REG_BLOCK_WIDTH:  return {25'd0, width_reg};
        default:                    return {25'd0, height_reg};
      endcase
    endfunction

    function logic [7:0] filter_taps(input logic [7:0] a, b, c, d);
      int pa, pb, pc, pd, acc;
      pa = a;
      pb = b;
      pc = c;
      pd = d;
      case (phase_reg)
        ftsl_pkg::PHASE_QUARTER:       acc = 25 * pb + 9 * pc - pa - pd;
        ftsl_pkg::PHASE_THREE_QUARTER: acc = 9 * pb + 25 * pc - pa - pd;
        default:                       acc = 18 * (pb + pc) - 2 * (pa + pd);
      endcase
      acc = (acc + 16) >>> 5;
      if (acc < 0) return 8'd0;
      if (acc > 255) return 8'hFF;
      return 8'(acc);
    endfunction

    function void take_ref_pixel(input logic [7:0] p);
      int w, h, s0, s1, s2, x;
      logic [1:0] m;
      logic [7:0] hval;
      subpel_result_t r;
      bit hit;
      w = eff_size(width_reg, MAX_W);
      h = eff_size(height_reg, MAX_H);
      s0 = row % 3;
      s1 = (row + 1) % 3;
      s2 = (row + 2) % 3;
      m = (mode_reg == ftsl_pkg::MODE_HORIZONTAL || mode_reg == ftsl_pkg::MODE_VERTICAL) ?
          mode_reg : ftsl_pkg::MODE_TWO_D;
      hval = (col >= 3) ? filter_taps(tail[0], tail[1], tail[2], p) : 8'd0;
      hit = 1'b0;
      case (m)
        ftsl_pkg::MODE_HORIZONTAL: begin
          if (col >= 3 && row >= 1 && row <= h) begin
            r.pix = hval;
            r.last = (row == h && col == w + 2);
            hit = 1'b1;
          end
        end
        ftsl_pkg::MODE_VERTICAL: begin
          if (col >= 1 && col <= w && row >= 3) begin
            r.pix = filter_taps(raw_rows[s0][col], raw_rows[s1][col], raw_rows[s2][col], p);
            r.last = (row == h + 2 && col == w);
            hit = 1'b1;
          end
        end
        default: begin
          if (col >= 3) begin
            x = col - 3;
            if (row >= 3) begin
              r.pix = filter_taps(filt_rows[s0][x], filt_rows[s1][x], filt_rows[s2][x], hval);
              r.last = (row == h + 2 && col == w + 2);
              hit = 1'b1;
            end
            filt_rows[s0][x] = hval;
          end
        end
      endcase
      if (hit) pending_pixels.push_back(r);
      raw_rows[s0][col] = p;
      tail[0] = tail[1];
      tail[1] = tail[2];
      tail[2] = p;
      col++;
      if (col >= w + 3) begin
        col = 0;
        row++;
        if (row >= h + 3) row = 0;
      end
    endfunction

    function void match_out_pixel(input logic [7:0] pix, input logic last);
      subpel_result_t e;
      if (pending_pixels.size() == 0) begin
        $display("%0t stray transfer: expected none, actual out_pixel=%0d block_end=%0b",
                 $time, pix, last);
        errors++;
        return;
      end
      e = pending_pixels.pop_front();
      if (pix !== e.pix) begin
        $display("%0t out_pixel: expected %0d, actual %0d", $time, e.pix, pix);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t block_end: expected %0b, actual %0b", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;
  logic        pixel_valid = 1'b0;
  logic        pixel_ready;
  logic [7:0]  ref_pixel = 8'd0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [7:0]  out_pixel;
  logic        block_end;

  subpel_checker sb;
  int sent_total = 0;
  int tx_idle_pct = 15;
  int rx_idle_pct = 62;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  four_tap_subpel_luma_filter u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .ref_pixel    (ref_pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_pixel    (out_pixel),
    .block_end    (block_end)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (pixel_valid && pixel_ready) sb.take_ref_pixel(ref_pixel);
      if (result_valid && result_ready) sb.match_out_pixel(out_pixel, block_end);
    end
  end

  // hold off for a long stretch on request, else stall at random
  always @(posedge clk) begin
    if (hold_left != 0) begin
      result_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      result_ready <= 1'b0;
      hold_seen <= hold_req;
      hold_left <= STALL_CYCLES;
    end else begin
      result_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic apb_xfer(input bit wr, input logic [1:0] idx, input logic [31:0] wdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (wr) begin
      sb.write_reg(idx, wdata);
    end else if (prdata !== sb.reg_value(idx)) begin
      $display("%0t register %0d: expected %0h, actual %0h",
               $time, idx, sb.reg_value(idx), prdata);
      sb.errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic regs_readback();
    for (int i = 0; i < 4; i++) apb_xfer(1'b0, 2'(i), 32'd0);
  endtask

  task automatic configure(input logic [1:0] m, ph, input logic [6:0] w, h,
                           input bit [1:0] mask);
    if (mask[0]) apb_xfer(1'b1, ftsl_pkg::REG_FILTER_MODE, {30'd0, m});
    if (mask[1]) apb_xfer(1'b1, ftsl_pkg::REG_PHASE, {30'd0, ph});
    apb_xfer(1'b1, ftsl_pkg::REG_BLOCK_WIDTH, {25'd0, w});
    apb_xfer(1'b1, ftsl_pkg::REG_BLOCK_HEIGHT, {25'd0, h});
    regs_readback();
  endtask

  task automatic push_pixel(input logic [7:0] value);
    int prof;
    pixel_valid <= 1'b1;
    ref_pixel <= value;
    do @(posedge clk); while (!pixel_ready);
    sent_total++;
    prof = (sent_total < 420) ? 0 : (sent_total < 840) ? 1 : 2;
    tx_idle_pct = (prof == 0) ? 15 : (prof == 1) ? 62 : 0;
    rx_idle_pct <= (prof == 0) ? 62 : (prof == 1) ? 15 : 0;
    if (sent_total == 300 || sent_total == 1000) hold_req <= hold_req + 1;
    while ($urandom_range(99) < tx_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic feed_window(input int count);
    repeat (count) push_pixel(($urandom_range(3) == 0) ? {8{1'($urandom)}} : 8'($urandom));
  endtask

  task automatic drain();
    do @(posedge clk); while (sb.pending() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(input logic [1:0] m, ph, input logic [6:0] w, h,
                           input bit [1:0] mask);
    int nwin;
    configure(m, ph, w, h, mask);
    nwin = (sb.window_len() > 200) ? 1 : $urandom_range(1, 3);
    repeat (nwin) feed_window(sb.window_len());
    if ($urandom_range(3) == 0) feed_window($urandom_range(1, sb.window_len() - 1));
    pixel_valid <= 1'b0;
    drain();
  endtask

  initial begin
    logic [6:0] w;
    logic [6:0] h;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    regs_readback();

    // clip both ways in the row filter, then break off a window part way
    configure(ftsl_pkg::MODE_TWO_D, ftsl_pkg::PHASE_QUARTER, 7'd1, 7'd1, 2'b11);
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        push_pixel(((r + ((c == 1 || c == 2) ? 1 : 0)) % 2) ? 8'hFF : 8'h00);
      end
    end
    repeat (7) push_pixel(8'($urandom));
    pixel_valid <= 1'b0;
    drain();

    run_phase(ftsl_pkg::MODE_HORIZONTAL, ftsl_pkg::PHASE_QUARTER, 7'd64, 7'd1, 2'b11);
    run_phase(ftsl_pkg::MODE_VERTICAL, ftsl_pkg::PHASE_THREE_QUARTER, 7'd2, 7'd127, 2'b11);
    run_phase(MODE_TWO_D_ALIAS, PHASE_HALF_ALIAS, 7'd0, 7'd0, 2'b11);
    run_phase(ftsl_pkg::MODE_TWO_D, ftsl_pkg::PHASE_HALF, 7'd100, 7'd1, 2'b11);
    run_phase(ftsl_pkg::MODE_TWO_D, ftsl_pkg::PHASE_THREE_QUARTER, 7'd1, 7'd64, 2'b11);

    while (sent_total < 1250) begin
      w = 7'($urandom_range(1, 8));
      h = 7'($urandom_range(1, 8));
      case ($urandom_range(9))
        0: w = 7'($urandom);
        1: h = 7'($urandom);
        2: w = 7'd0;
        3: h = 7'd0;
        default: ;
      endcase
      run_phase(2'($urandom), 2'($urandom), w, h, 2'($urandom));
    end

    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/ftsl_pkg.sv
hdl/ftsl_line_ram.sv
hdl/ftsl_window_ctrl.sv
hdl/ftsl_filter_pipe.sv
hdl/four_tap_subpel_luma_filter.sv
tb/tb.sv
